// ----- design/fraction_multiply_reduce_defines.svh -----
// ----------------------------------------------------------------------------
// fraction_multiply_reduce_defines
// Assertion macros shared by the checker files of this block.
// ----------------------------------------------------------------------------
`ifndef FRACTION_MULTIPLY_REDUCE_DEFINES_SVH
`define FRACTION_MULTIPLY_REDUCE_DEFINES_SVH

// Property checked on every clock edge outside of reset.
`define FMR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define FMR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/fmr_pkg.sv -----
// ----------------------------------------------------------------------------
// fmr_pkg
// Widths, request/result types and status types of the fraction multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package fmr_pkg;

  // Operand width of each fraction field
  localparam int OPERAND_WIDTH = 16;
  // Exact product width
  localparam int PROD_WIDTH    = 2 * OPERAND_WIDTH;
  // Subtractor width: one spare bit for the shifted remainder
  localparam int ALU_WIDTH     = PROD_WIDTH + 1;
  // Result field width
  localparam int RES_WIDTH     = 32;
  // Width used to sign the quotient before wrapping to the result width
  localparam int EXT_WIDTH     = (PROD_WIDTH > RES_WIDTH) ? PROD_WIDTH : RES_WIDTH;
  // Bit counter / shift count width
  localparam int CNT_WIDTH     = $clog2(PROD_WIDTH);

  typedef struct packed {
    logic signed [OPERAND_WIDTH-1:0] num_a;
    logic signed [OPERAND_WIDTH-1:0] den_a;
    logic signed [OPERAND_WIDTH-1:0] num_b;
    logic signed [OPERAND_WIDTH-1:0] den_b;
  } fmr_req_t;

  typedef struct packed {
    logic signed [RES_WIDTH-1:0] res_num;
    logic signed [RES_WIDTH-1:0] res_den;
    logic                        zero_gcd_error;
  } fmr_rsp_t;

  // Compare/subtract unit result
  typedef struct packed {
    logic                 ge;
    logic [ALU_WIDTH-1:0] diff;
    logic [ALU_WIDTH-1:0] absdiff;
  } fmr_alu_t;

  // Core status toward the handshake logic
  typedef struct packed {
    logic idle;
    logic done;
  } fmr_stat_t;

endpackage

`default_nettype wire

// ----- design/fraction_multiply_reduce.sv -----
// A request passes through the core in this order: the two products on the one
// multiplier, binary gcd steps until one side is zero plus a step that sees the
// loop end, two restoring divisions of P = 2*OPERAND_WIDTH (32 by default)
// quotient bits each, a hand-over of the result to the output register and a
// return to idle to take the next request. A request whose products are both
// zero skips the divisions and ends with the error flag. The time is set by the
// one compare/subtract unit, which runs the gcd loop one step per cycle and then
// the divisions one quotient bit per cycle. in_ready is high only while the core
// is idle; a finished result sits in the output register and the next request
// can be taken meanwhile. While that register is still held by the receiver, a
// second finished result waits in the core and the input stalls.
// ----------------------------------------------------------------------------
// fraction_multiply_reduce
// Multiplies two signed fractions and reduces the result by its gcd.
// ----------------------------------------------------------------------------
`default_nettype none

module fraction_multiply_reduce (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire fmr_pkg::fmr_req_t in_req,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output fmr_pkg::fmr_rsp_t      out_rsp
);
  import fmr_pkg::*;

  fmr_stat_t stat;
  fmr_rsp_t  core_rsp;
  logic      start;
  logic      ack;

  // Request taken only while the core is idle
  assign in_ready = stat.idle;
  assign start    = in_valid && in_ready;
  // Finished result moves out when the output register is free
  assign ack      = stat.done && (!out_valid || out_ready);

  fmr_core u_core (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .req   (in_req),
    .ack   (ack),
    .stat  (stat),
    .rsp   (core_rsp)
  );

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ack) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (ack) begin
      out_rsp <= core_rsp;
    end
  end

endmodule

`default_nettype wire

// ----- design/fmr_alu.sv -----
// ----------------------------------------------------------------------------
// fmr_alu
// Shared compare/subtract unit used by the gcd loop and the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module fmr_alu (
  input  wire logic [fmr_pkg::ALU_WIDTH-1:0] x,
  input  wire logic [fmr_pkg::ALU_WIDTH-1:0] y,
  output fmr_pkg::fmr_alu_t                  res
);
  import fmr_pkg::*;

  logic [ALU_WIDTH-1:0] x_minus_y;
  logic [ALU_WIDTH-1:0] y_minus_x;

  // Both differences; the compare picks the nonnegative one
  always_comb begin
    x_minus_y   = x - y;
    y_minus_x   = y - x;
    res.ge      = (x >= y);
    res.diff    = x_minus_y;
    res.absdiff = res.ge ? x_minus_y : y_minus_x;
  end

endmodule

`default_nettype wire

// ----- design/fmr_core.sv -----
// ----------------------------------------------------------------------------
// fmr_core
// Sequencer: two products on one multiplier, binary gcd and two restoring
// divisions on the shared compare/subtract unit.
// ----------------------------------------------------------------------------
`default_nettype none

module fmr_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire fmr_pkg::fmr_req_t req,
  input  wire logic              ack,
  output fmr_pkg::fmr_stat_t     stat,
  output fmr_pkg::fmr_rsp_t      rsp
);
  import fmr_pkg::*;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_MUL_NUM = 3'd1;
  localparam logic [2:0] ST_MUL_DEN = 3'd2;
  localparam logic [2:0] ST_GCD     = 3'd3;
  localparam logic [2:0] ST_DIV_NUM = 3'd4;
  localparam logic [2:0] ST_DIV_DEN = 3'd5;
  localparam logic [2:0] ST_DONE    = 3'd6;

  localparam logic [CNT_WIDTH-1:0] CNT_LAST = CNT_WIDTH'(PROD_WIDTH - 1);

  logic [2:0]               state;
  logic [2:0]               state_next;
  fmr_req_t                 req_q;
  logic                     sign_n;
  logic                     sign_d;
  logic [PROD_WIDTH-1:0]    nm;
  logic [PROD_WIDTH-1:0]    dm;
  logic [PROD_WIDTH-1:0]    ga;
  logic [PROD_WIDTH-1:0]    gb;
  logic [CNT_WIDTH-1:0]     k;
  logic [PROD_WIDTH-1:0]    g;
  logic [PROD_WIDTH-1:0]    rem;
  logic [PROD_WIDTH-1:0]    quot;
  logic [PROD_WIDTH-1:0]    qn;
  logic [CNT_WIDTH-1:0]     cnt;
  fmr_rsp_t                 rsp_q;

  logic [OPERAND_WIDTH-1:0] mul_x;
  logic [OPERAND_WIDTH-1:0] mul_y;
  logic [PROD_WIDTH-1:0]    prod;
  logic [ALU_WIDTH-1:0]     div_shift;
  logic [ALU_WIDTH-1:0]     alu_x;
  logic [ALU_WIDTH-1:0]     alu_y;
  fmr_alu_t                 alu_res;
  logic [PROD_WIDTH-1:0]    rem_next;
  logic [PROD_WIDTH-1:0]    quot_next;
  logic                     gcd_end;

  // Magnitude of a two's complement operand; the most negative value fits unsigned
  function automatic logic [OPERAND_WIDTH-1:0] mag_of(input logic [OPERAND_WIDTH-1:0] v);
    return v[OPERAND_WIDTH-1] ? (~v + 1'b1) : v;
  endfunction

  // Apply the product sign and wrap to the result width
  function automatic logic [RES_WIDTH-1:0] apply_sign(input logic [PROD_WIDTH-1:0] mag,
                                                      input logic neg);
    logic [EXT_WIDTH-1:0] ext;
    ext = EXT_WIDTH'(mag);
    if (neg) begin
      ext = ~ext + 1'b1;
    end
    return ext[RES_WIDTH-1:0];
  endfunction

  // Single multiplier, numerator product first, then denominator product
  always_comb begin
    if (state == ST_MUL_NUM) begin
      mul_x = mag_of(req_q.num_a);
      mul_y = mag_of(req_q.num_b);
    end else begin
      mul_x = mag_of(req_q.den_a);
      mul_y = mag_of(req_q.den_b);
    end
    prod = PROD_WIDTH'(mul_x) * PROD_WIDTH'(mul_y);
  end

  // Shared unit operands: gcd difference or divider trial subtract
  always_comb begin
    div_shift = {rem, quot[PROD_WIDTH-1]};
    if (state == ST_GCD) begin
      alu_x = {1'b0, ga};
      alu_y = {1'b0, gb};
    end else begin
      alu_x = div_shift;
      alu_y = {1'b0, g};
    end
  end

  fmr_alu u_alu (
    .x   (alu_x),
    .y   (alu_y),
    .res (alu_res)
  );

  // One restoring division step
  always_comb begin
    rem_next  = alu_res.ge ? alu_res.diff[PROD_WIDTH-1:0] : div_shift[PROD_WIDTH-1:0];
    quot_next = {quot[PROD_WIDTH-2:0], alu_res.ge};
    gcd_end   = (ga == '0) || (gb == '0);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (start) state_next = ST_MUL_NUM;
      ST_MUL_NUM: state_next = ST_MUL_DEN;
      ST_MUL_DEN: state_next = ST_GCD;
      ST_GCD: begin
        if ((ga == '0) && (gb == '0)) begin
          state_next = ST_DONE;
        end else if (gcd_end) begin
          state_next = ST_DIV_NUM;
        end
      end
      ST_DIV_NUM: if (cnt == '0) state_next = ST_DIV_DEN;
      ST_DIV_DEN: if (cnt == '0) state_next = ST_DONE;
      ST_DONE:    if (ack) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) req_q <= req;
      end
      ST_MUL_NUM: begin
        nm     <= prod;
        sign_n <= req_q.num_a[OPERAND_WIDTH-1] ^ req_q.num_b[OPERAND_WIDTH-1];
      end
      ST_MUL_DEN: begin
        dm     <= prod;
        sign_d <= req_q.den_a[OPERAND_WIDTH-1] ^ req_q.den_b[OPERAND_WIDTH-1];
        ga     <= nm;
        gb     <= prod;
        k      <= '0;
      end
      ST_GCD: begin
        if ((ga == '0) && (gb == '0)) begin
          rsp_q.res_num        <= '0;
          rsp_q.res_den        <= '0;
          rsp_q.zero_gcd_error <= 1'b1;
        end else if (gcd_end) begin
          // One side is zero: the other, scaled by the shared powers of two
          g    <= (ga | gb) << k;
          quot <= nm;
          rem  <= '0;
          cnt  <= CNT_LAST;
        end else if (!ga[0] && !gb[0]) begin
          ga <= ga >> 1;
          gb <= gb >> 1;
          k  <= k + 1'b1;
        end else if (!ga[0]) begin
          ga <= ga >> 1;
        end else if (!gb[0]) begin
          gb <= gb >> 1;
        end else if (alu_res.ge) begin
          ga <= alu_res.absdiff[PROD_WIDTH:1];
        end else begin
          gb <= alu_res.absdiff[PROD_WIDTH:1];
        end
      end
      ST_DIV_NUM: begin
        if (cnt == '0) begin
          qn   <= quot_next;
          quot <= dm;
          rem  <= '0;
          cnt  <= CNT_LAST;
        end else begin
          quot <= quot_next;
          rem  <= rem_next;
          cnt  <= cnt - 1'b1;
        end
      end
      ST_DIV_DEN: begin
        quot <= quot_next;
        rem  <= rem_next;
        cnt  <= cnt - 1'b1;
        if (cnt == '0) begin
          rsp_q.res_num        <= apply_sign(qn, sign_n);
          rsp_q.res_den        <= apply_sign(quot_next, sign_d);
          rsp_q.zero_gcd_error <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  assign stat.idle = (state == ST_IDLE);
  assign stat.done = (state == ST_DONE);
  assign rsp       = rsp_q;

endmodule

`default_nettype wire

// ----- design/fmr_checker.sv -----
// ----------------------------------------------------------------------------
// fmr_checker
// Port-level checks of the fraction multiplier, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fraction_multiply_reduce_defines.svh"

module fmr_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire fmr_pkg::fmr_req_t in_req,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire fmr_pkg::fmr_rsp_t out_rsp
);
  import fmr_pkg::*;

  logic rsp_zero;
  logic rsp_err;

  // Result shows 0/0
  assign rsp_zero = (out_rsp.res_num == '0) && (out_rsp.res_den == '0);
  assign rsp_err  = out_rsp.zero_gcd_error;

  // Held result stays put
  `FMR_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_rsp), "result moved")
  // Error result carries 0/0
  `FMR_ASSERT(a_err_zero, out_valid && rsp_err |-> rsp_zero, "error result not 0/0")
  // Reduced result never 0/0 without the error flag
  `FMR_ASSERT(a_ok_nonzero, out_valid && !rsp_err |-> !rsp_zero, "0/0 without error")
  // Accepted request keeps the core busy
  `FMR_ASSERT(a_busy, in_valid && in_ready |=> !in_ready, "ready right after accept")
  // Reset leaves no result pending
  `FMR_ASSERT_ALWAYS(a_rst_empty, rst |=> !out_valid, "result valid after reset")

endmodule

bind fraction_multiply_reduce fmr_checker u_fmr_checker (.*);

`default_nettype wire
